@@ src/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared assertion macros, clocked on aclk, held off during reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Generic clocked property check.
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) \
        else $error(msg);

// Same-cycle implication: when ante holds, cons must hold.
`define ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |-> (cons)) else $error(msg);

`endif

@@ src/hsvc_pkg.sv @@
// ----------------------------------------------------------------------------
// hsvc_pkg
// Shared types and constants of the HSV to RGB converter.
// ----------------------------------------------------------------------------
package hsvc_pkg;

    // Hue in 1/16 degree: one full turn and one 60 degree sector
    parameter logic [12:0] HUE_FULL   = 13'd5760;
    parameter logic [12:0] HUE_SECTOR = 13'd960;
    // Saturation full scale (1.0)
    parameter logic [8:0]  SAT_ONE    = 9'd256;
    // Denominator of the q and t levels: 960 * 256
    parameter logic [17:0] SCALE_QT   = 18'd245760;
    // Reciprocal of 15 in 16 fractional bits, exact for inputs below 4681
    parameter logic [12:0] RECIP15    = 13'd4370;
    // Largest value fed to the divide-by-15 step (255 * 15)
    parameter logic [11:0] DIV15_MAX  = 12'd3825;

    typedef enum logic [2:0] {
        SEC_R_TO_Y = 3'd0,
        SEC_Y_TO_G = 3'd1,
        SEC_G_TO_C = 3'd2,
        SEC_C_TO_B = 3'd3,
        SEC_B_TO_M = 3'd4,
        SEC_M_TO_R = 3'd5
    } sector_t;

    typedef struct packed {
        sector_t     sector;
        logic [9:0]  frac;    // position within the sector, 0..959
    } hue_split_t;

endpackage

@@ src/hsvc_sector.sv @@
// ----------------------------------------------------------------------------
// hsvc_sector
// Folds out-of-circle hue to zero and splits it into sector and fraction.
// ----------------------------------------------------------------------------
module hsvc_sector (
    input  logic [15:0]         hue,
    output hsvc_pkg::hue_split_t split
);

    logic [12:0] hue_c;
    logic [12:0] base;

    always_comb begin
        hue_c = (hue >= 16'(hsvc_pkg::HUE_FULL)) ? 13'd0 : hue[12:0];

        // Thresholds are multiples of 960; compare from the top down
        if (hue_c >= 13'd4800) begin
            split.sector = hsvc_pkg::SEC_M_TO_R;
            base         = 13'd4800;
        end else if (hue_c >= 13'd3840) begin
            split.sector = hsvc_pkg::SEC_B_TO_M;
            base         = 13'd3840;
        end else if (hue_c >= 13'd2880) begin
            split.sector = hsvc_pkg::SEC_C_TO_B;
            base         = 13'd2880;
        end else if (hue_c >= 13'd1920) begin
            split.sector = hsvc_pkg::SEC_G_TO_C;
            base         = 13'd1920;
        end else if (hue_c >= hsvc_pkg::HUE_SECTOR) begin
            split.sector = hsvc_pkg::SEC_Y_TO_G;
            base         = hsvc_pkg::HUE_SECTOR;
        end else begin
            split.sector = hsvc_pkg::SEC_R_TO_Y;
            base         = 13'd0;
        end

        split.frac = 10'(hue_c - base);
    end

endmodule

@@ src/hsv_to_rgb_converter.sv @@
// ----------------------------------------------------------------------------
// hsv_to_rgb_converter
// Streaming HSV to 8-bit RGB pixel converter, four register stages.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel s_axis_*: one HSV pixel per transfer. Hue in 1/16 degree
//   (5760 and up fold to 0), saturation in 1/256 (above 256 clamps to full),
//   brightness 0..255.
//   Output channel m_axis_*: one RGB pixel per input transfer, in order.
//   Each pixel is registered in stages 1, 2 and 3, then in the output
//   register, whose valid bit drives m_axis_tvalid.
//   Throughput: one pixel per clock while the output is not stalled. Stage
//   depth is set by the multipliers: saturation products, then brightness
//   times level, then the reciprocal multiply that divides by 15.
//   Each stage carries its own valid bit and advances whenever the stage
//   after it is empty or moving, so bubbles collapse and the input keeps
//   accepting while a finished pixel waits on m_axis_tready.
//   When the receiver stalls, the output holds and the pipeline fills; once
//   all four stages are full, s_axis_tready drops. Nothing is lost or repeated.
//   Reset (aresetn low, synchronous) empties the pipeline; it keeps no other
//   state.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module hsv_to_rgb_converter (
    input  logic        aclk,
    input  logic        aresetn,
    // Input pixel
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,   // [15:0] hue, [24:16] saturation,
                                        // [32:25] brightness, [39:33] zero
    // Output pixel
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata    // [7:0] red, [15:8] green, [23:16] blue
);

    // ---------------- input unpack ----------------
    logic [15:0] in_hue;
    logic [8:0]  in_sat;
    logic [7:0]  in_v;

    assign in_hue = s_axis_tdata[15:0];
    assign in_sat = s_axis_tdata[24:16];
    assign in_v   = s_axis_tdata[32:25];

    // ---------------- per-stage handshake ----------------
    logic s1_valid_reg, s2_valid_reg, s3_valid_reg, out_valid_reg;
    logic rdy1, rdy2, rdy3, rdy4;

    // A stage may load when it is empty or its content moves on this cycle
    assign rdy4 = !out_valid_reg || m_axis_tready;
    assign rdy3 = !s3_valid_reg  || rdy4;
    assign rdy2 = !s2_valid_reg  || rdy3;
    assign rdy1 = !s1_valid_reg  || rdy2;

    assign s_axis_tready = rdy1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (rdy1) s1_valid_reg  <= s_axis_tvalid;
            if (rdy2) s2_valid_reg  <= s1_valid_reg;
            if (rdy3) s3_valid_reg  <= s2_valid_reg;
            if (rdy4) out_valid_reg <= s3_valid_reg;
        end
    end

    // ---------------- stage 1: hue split, saturation clamp ----------------
    hsvc_pkg::hue_split_t split_next, s1_split_reg;
    logic [8:0]           s1_sat_next, s1_sat_reg;
    logic [7:0]           s1_v_reg;

    hsvc_sector u_sector (
        .hue   (in_hue),
        .split (split_next)
    );

    assign s1_sat_next = (in_sat > hsvc_pkg::SAT_ONE) ? hsvc_pkg::SAT_ONE : in_sat;

    always_ff @(posedge aclk) begin
        if (rdy1 && s_axis_tvalid) begin
            s1_split_reg <= split_next;
            s1_sat_reg   <= s1_sat_next;
            s1_v_reg     <= in_v;
        end
    end

    // ---------------- stage 2: saturation products, p level ----------------
    logic [18:0]       sf_full, sg_full;
    logic [16:0]       p_prod;
    logic [17:0]       s2_sf_reg, s2_sg_reg;
    logic [7:0]        s2_p_reg, s2_v_reg;
    hsvc_pkg::sector_t s2_sector_reg;

    always_comb begin
        sf_full = 19'(s1_sat_reg) * 19'(s1_split_reg.frac);
        sg_full = 19'(s1_sat_reg) * 19'(10'(hsvc_pkg::HUE_SECTOR) - s1_split_reg.frac);
        // v * (256 - S), then drop 8 bits for the /256
        p_prod  = 17'(s1_v_reg) * 17'(hsvc_pkg::SAT_ONE - s1_sat_reg);
    end

    always_ff @(posedge aclk) begin
        if (rdy2 && s1_valid_reg) begin
            s2_sf_reg     <= sf_full[17:0];
            s2_sg_reg     <= sg_full[17:0];
            s2_p_reg      <= p_prod[15:8];
            s2_v_reg      <= s1_v_reg;
            s2_sector_reg <= s1_split_reg.sector;
        end
    end

    // ---------------- stage 3: v * level, divide by 2^14 ----------------
    // 245760 = 2^14 * 15, so only a divide by 15 is left for stage 4
    logic [25:0]       q_prod, t_prod;
    logic [11:0]       s3_yq_reg, s3_yt_reg;
    logic [7:0]        s3_p_reg, s3_v_reg;
    hsvc_pkg::sector_t s3_sector_reg;

    always_comb begin
        q_prod = 26'(s2_v_reg) * 26'(hsvc_pkg::SCALE_QT - s2_sf_reg);
        t_prod = 26'(s2_v_reg) * 26'(hsvc_pkg::SCALE_QT - s2_sg_reg);
    end

    always_ff @(posedge aclk) begin
        if (rdy3 && s2_valid_reg) begin
            s3_yq_reg     <= q_prod[25:14];
            s3_yt_reg     <= t_prod[25:14];
            s3_p_reg      <= s2_p_reg;
            s3_v_reg      <= s2_v_reg;
            s3_sector_reg <= s2_sector_reg;
        end
    end

    // ---------------- stage 4: divide by 15, component order ----------------
    logic [24:0] q_recip, t_recip;
    logic [7:0]  q_lvl, t_lvl;
    logic [7:0]  red_next, green_next, blue_next;
    logic [7:0]  red_reg, green_reg, blue_reg;

    always_comb begin
        q_recip = 25'(s3_yq_reg) * 25'(hsvc_pkg::RECIP15);
        t_recip = 25'(s3_yt_reg) * 25'(hsvc_pkg::RECIP15);
        q_lvl   = q_recip[23:16];
        t_lvl   = t_recip[23:16];

        case (s3_sector_reg)
            hsvc_pkg::SEC_R_TO_Y: begin
                red_next = s3_v_reg; green_next = t_lvl;    blue_next = s3_p_reg;
            end
            hsvc_pkg::SEC_Y_TO_G: begin
                red_next = q_lvl;    green_next = s3_v_reg; blue_next = s3_p_reg;
            end
            hsvc_pkg::SEC_G_TO_C: begin
                red_next = s3_p_reg; green_next = s3_v_reg; blue_next = t_lvl;
            end
            hsvc_pkg::SEC_C_TO_B: begin
                red_next = s3_p_reg; green_next = q_lvl;    blue_next = s3_v_reg;
            end
            hsvc_pkg::SEC_B_TO_M: begin
                red_next = t_lvl;    green_next = s3_p_reg; blue_next = s3_v_reg;
            end
            default: begin
                red_next = s3_v_reg; green_next = s3_p_reg; blue_next = q_lvl;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (rdy4 && s3_valid_reg) begin
            red_reg   <= red_next;
            green_reg <= green_next;
            blue_reg  <= blue_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {blue_reg, green_reg, red_reg};

    // ---------------- checks ----------------
    `ASSERT_IMPLY(a_frac_range, s1_valid_reg,
        s1_split_reg.frac < 10'(hsvc_pkg::HUE_SECTOR), "sector fraction out of range")
    `ASSERT_IMPLY(a_level_nonneg, s2_valid_reg,
        (s2_sf_reg <= hsvc_pkg::SCALE_QT) && (s2_sg_reg <= hsvc_pkg::SCALE_QT),
        "saturation product exceeds level scale")
    `ASSERT_IMPLY(a_div15_range, s3_valid_reg,
        (s3_yq_reg <= hsvc_pkg::DIV15_MAX) && (s3_yt_reg <= hsvc_pkg::DIV15_MAX),
        "divide-by-15 input beyond reciprocal range")
    `ASSERT_CLK(a_full_stall, (!s_axis_tready) |->
        (s1_valid_reg && s2_valid_reg && s3_valid_reg && out_valid_reg && !m_axis_tready),
        "input stalled while pipeline has room")

endmodule

@@ tb/tb.sv @@
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the streaming HSV to RGB pixel converter.
// Pixels go in through a queue-fed driver. Each pixel transfer accepted on the
// input is run through a bit-exact fixed-point predictor of the conversion.
// A monitor compares every output transfer, in order, against the oldest
// predicted pixel. Both channels idle and stall at random. There are also
// calm stretches with no gaps on either side.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    // Fixed-point scales of the conversion
    localparam int unsigned HUE_TURN = 5760;    // 360 degrees in 1/16 degree
    localparam int unsigned HUE_SPAN = 960;     // one 60 degree sector
    localparam int unsigned SAT_FULL = 256;     // saturation 1.0
    localparam int unsigned QT_SCALE = 245760;  // 960 * 256

    localparam int RESET_CYCLES  = 12;
    localparam int RANDOM_PIXELS = 600;
    localparam int DRAIN_CYCLES  = 20;          // idle wait after the last check
    localparam int CYCLE_LIMIT   = 400000;

    typedef struct {
        logic [15:0] hue;
        logic [8:0]  sat;
        logic [7:0]  bright;
        int          gap;       // idle cycles on the input after this transfer
    } hsv_pixel_t;

    typedef struct packed {
        logic [7:0] blue;
        logic [7:0] green;
        logic [7:0] red;
    } rgb_pixel_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [39:0] s_axis_tdata = '0;     // [15:0] hue, [24:16] saturation,
                                        // [32:25] brightness, [39:33] zero
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [23:0] m_axis_tdata;          // [7:0] red, [15:8] green, [23:16] blue

    hsv_pixel_t  pixel_pending[$];
    rgb_pixel_t  rgb_expected[$];

    logic        in_took = 1'b0;        // input transfer at the last rising edge
    int          in_gap = 0;
    int          out_hold = 0;
    int          cycle_cnt = 0;
    int          sent_cnt = 0;
    int          checked_cnt = 0;
    int          err_cnt = 0;
    int          wrapped_cnt = 0;
    int          clamped_cnt = 0;
    int          gray_cnt = 0;

    hsv_to_rgb_converter uut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial begin
        forever #2 aclk = ~aclk;
    end

    // Expected RGB of one HSV pixel: sector and fraction, then p/q/t levels,
    // all floors in unsigned integer math.
    function automatic rgb_pixel_t hsv_to_rgb_predict(logic [15:0] hue, logic [8:0] sat,
                                                      logic [7:0] bright);
        int unsigned       h, s, v, frac, p, q, t;
        hsvc_pkg::sector_t sec;
        rgb_pixel_t        px;
        h    = (32'(hue) >= HUE_TURN) ? 0 : 32'(hue);   // out of circle folds to 0
        s    = (32'(sat) > SAT_FULL) ? SAT_FULL : 32'(sat);
        v    = 32'(bright);
        sec  = hsvc_pkg::sector_t'(3'(h / HUE_SPAN));
        frac = h % HUE_SPAN;
        p = (v * (SAT_FULL - s)) / SAT_FULL;
        q = (v * (QT_SCALE - s * frac)) / QT_SCALE;
        t = (v * (QT_SCALE - s * (HUE_SPAN - frac))) / QT_SCALE;
        case (sec)
            hsvc_pkg::SEC_R_TO_Y: px = '{red: v[7:0], green: t[7:0], blue: p[7:0]};
            hsvc_pkg::SEC_Y_TO_G: px = '{red: q[7:0], green: v[7:0], blue: p[7:0]};
            hsvc_pkg::SEC_G_TO_C: px = '{red: p[7:0], green: v[7:0], blue: t[7:0]};
            hsvc_pkg::SEC_C_TO_B: px = '{red: p[7:0], green: q[7:0], blue: v[7:0]};
            hsvc_pkg::SEC_B_TO_M: px = '{red: t[7:0], green: p[7:0], blue: v[7:0]};
            default:              px = '{red: v[7:0], green: p[7:0], blue: q[7:0]};
        endcase
        return px;
    endfunction

    // Mostly back to back or short gaps, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 10);
        else
            return $urandom_range(20, 60);
    endfunction

    task automatic queue_pixel(logic [15:0] hue, logic [8:0] sat, logic [7:0] bright,
                               int gap);
        hsv_pixel_t px;
        px.hue    = hue;
        px.sat    = sat;
        px.bright = bright;
        px.gap    = gap;
        pixel_pending.push_back(px);
    endtask

    // Input driver: changes at the falling edge, holds a pixel until transferred
    always @(negedge aclk) begin
        hsv_pixel_t px;
        if (!aresetn) begin
            s_axis_tvalid <= 1'b0;
        end else if (!s_axis_tvalid || in_took) begin
            if (in_gap > 0) begin
                s_axis_tvalid <= 1'b0;
                in_gap <= in_gap - 1;
            end else if (pixel_pending.size() > 0) begin
                px = pixel_pending.pop_front();
                s_axis_tvalid <= 1'b1;
                s_axis_tdata  <= {7'd0, px.bright, px.sat, px.hue};
                in_gap <= px.gap;
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // Output stalls; every fourth window of the cycle count runs without stalls
    always @(negedge aclk) begin
        if (!aresetn) begin
            m_axis_tready <= 1'b0;
        end else if ((cycle_cnt / 2000) % 4 == 3) begin
            m_axis_tready <= 1'b1;
            out_hold <= 0;
        end else if (out_hold > 0) begin
            m_axis_tready <= 1'b0;
            out_hold <= out_hold - 1;
        end else begin
            m_axis_tready <= 1'b1;
            out_hold <= pick_gap();
        end
    end

    // Monitor: predicts on input transfers, checks output transfers
    always @(posedge aclk) begin
        rgb_pixel_t got, want;
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("%0t: timeout after %0d cycles, %0d pixels still expected",
                     $time, cycle_cnt, rgb_expected.size());
            $display("*** FAILED ***");
            $finish;
        end else if (aresetn) begin
            in_took <= s_axis_tvalid && s_axis_tready;
            if (s_axis_tvalid && s_axis_tready) begin
                rgb_expected.push_back(hsv_to_rgb_predict(s_axis_tdata[15:0],
                                                          s_axis_tdata[24:16],
                                                          s_axis_tdata[32:25]));
                sent_cnt <= sent_cnt + 1;
                if (s_axis_tdata[15:0] >= HUE_TURN)
                    wrapped_cnt <= wrapped_cnt + 1;
                if (s_axis_tdata[24:16] > SAT_FULL)
                    clamped_cnt <= clamped_cnt + 1;
                if (s_axis_tdata[24:16] == 0)
                    gray_cnt <= gray_cnt + 1;
            end
            if (m_axis_tvalid && m_axis_tready) begin
                got = m_axis_tdata;
                if (rgb_expected.size() == 0) begin
                    $display("%0t: unexpected output pixel, expected none, got %06h",
                             $time, got);
                    err_cnt <= err_cnt + 1;
                end else begin
                    want = rgb_expected.pop_front();
                    checked_cnt <= checked_cnt + 1;
                    if (got.red !== want.red || got.green !== want.green ||
                        got.blue !== want.blue) begin
                        $display("%0t: mismatch, exp r=%0d g=%0d b=%0d, got r=%0d g=%0d b=%0d",
                                 $time, want.red, want.green, want.blue,
                                 got.red, got.green, got.blue);
                        err_cnt <= err_cnt + 1;
                    end
                end
            end
        end
    end

    initial begin
        bit          calm;
        logic [15:0] hue;
        logic [8:0]  sat;
        logic [7:0]  bright;
        int          r;

        // Directed: sector edges, out-of-circle hues, saturation limits, v extremes
        queue_pixel(16'd0,     9'd256, 8'd255, 0);
        queue_pixel(16'd959,   9'd256, 8'd255, 0);
        queue_pixel(16'd960,   9'd256, 8'd255, 0);
        queue_pixel(16'd1919,  9'd255, 8'd200, 0);
        queue_pixel(16'd1920,  9'd256, 8'd255, 1);
        queue_pixel(16'd2879,  9'd128, 8'd255, 0);
        queue_pixel(16'd2880,  9'd256, 8'd255, 0);
        queue_pixel(16'd3840,  9'd1,   8'd255, 2);
        queue_pixel(16'd4800,  9'd256, 8'd1,   0);
        queue_pixel(16'd5759,  9'd256, 8'd255, 0);
        queue_pixel(16'd5760,  9'd256, 8'd255, 0);   // wraps to red
        queue_pixel(16'd65535, 9'd200, 8'd255, 0);   // wraps to red
        queue_pixel(16'd6000,  9'd256, 8'd77,  3);
        queue_pixel(16'd1000,  9'd0,   8'd255, 0);   // gray
        queue_pixel(16'd4000,  9'd0,   8'd0,   0);
        queue_pixel(16'd3000,  9'd257, 8'd255, 0);   // clamps to full
        queue_pixel(16'd500,   9'd511, 8'd255, 0);
        queue_pixel(16'd5000,  9'd256, 8'd0,   0);
        queue_pixel(16'd2400,  9'd256, 8'd128, 5);
        queue_pixel(16'd480,   9'd256, 8'd255, 0);
        queue_pixel(16'd43690, 9'd341, 8'd170, 0);   // alternating bit patterns
        queue_pixel(16'd21845, 9'd170, 8'd85,  0);

        // Random: mostly in-range pixels, some wrapped hues and clamped saturation.
        // Every fifth block of 50 pixels runs back to back.
        for (int i = 0; i < RANDOM_PIXELS; i++) begin
            calm = ((i / 50) % 5 == 2);
            r = $urandom_range(0, 99);
            if (r < 75)
                hue = 16'($urandom_range(0, HUE_TURN - 1));
            else if (r < 85)
                hue = 16'($urandom_range(HUE_TURN, 65535));
            else
                hue = 16'(HUE_SPAN * $urandom_range(0, 6) - $urandom_range(0, 1));
            r = $urandom_range(0, 99);
            if (r < 70)
                sat = 9'($urandom_range(0, SAT_FULL));
            else if (r < 85)
                sat = ($urandom_range(0, 1) != 0) ? 9'd256 : 9'd0;
            else
                sat = 9'($urandom_range(SAT_FULL + 1, 511));
            r = $urandom_range(0, 99);
            if (r < 80)
                bright = 8'($urandom_range(0, 255));
            else
                bright = ($urandom_range(0, 1) != 0) ? 8'd255 : 8'd0;
            queue_pixel(hue, sat, bright, calm ? 0 : pick_gap());
        end

        repeat (RESET_CYCLES) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Drain: all pixels sent, every prediction checked, then an idle wait
        while (pixel_pending.size() > 0 || s_axis_tvalid || rgb_expected.size() > 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("Converted %0d pixels, %0d outputs checked, %0d errors",
                 sent_cnt, checked_cnt, err_cnt);
        $display("Hues past full turn: %0d, saturation clamped: %0d, zero saturation: %0d",
                 wrapped_cnt, clamped_cnt, gray_cnt);
        if (err_cnt == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
